// ===== rtl/ipv6fp_pkg.sv =====
`default_nettype none
package ipv6fp_pkg;

	localparam logic [1:0] KIND_WHOLE   = 2'd0;
	localparam logic [1:0] KIND_FRAG    = 2'd1;
	localparam logic [1:0] KIND_REPORT  = 2'd2;
	localparam logic [1:0] KIND_DROPPED = 2'd3;

	localparam logic [15:0] MTU_RESET     = 16'd1500;
	localparam logic [16:0] IPV6_HDR_LEN  = 17'd40;
	localparam logic [16:0] FRAG_HDR_LEN  = 17'd8;
	localparam logic [15:0] FRAG_OVERHEAD = 16'd48;
	localparam logic [15:0] REPORT_DELTA  = 16'd28;
	localparam logic [15:0] MIN_FRAG_MTU  = 16'd56;
	localparam logic [5:0]  LAST_FRAG_IDX = 6'd63;

	typedef struct packed {
		logic [7:0]  head_size;
		logic [15:0] body_size;
		logic        no_frag;
		logic        has_fragment_header;
		logic [12:0] in_frag_offset;
		logic        in_mf_flag;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [12:0] frag_offset;
		logic        part_select;
		logic [15:0] part_byte_offset;
		logic [15:0] frag_size;
		logic        mf_flag;
		logic        new_frag_header;
		logic [15:0] report_mtu;
		logic        last;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_CUT
	} state_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic cut;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/ipv6fp_ctrl.sv =====
`default_nettype none
module ipv6fp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ipv6fp_pkg::dp_stat_t stat,
	output ipv6fp_pkg::dp_cmd_t  cmd,
	output logic                busy
);
	import ipv6fp_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = stat.done ? ST_IDLE : ST_CUT;
			end
			ST_CUT: begin
				if (stat.done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
			end
			ST_CUT: begin
				cmd.cut = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/ipv6fp_datapath.sv =====
`default_nettype none
module ipv6fp_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_wdata,
	input  ipv6fp_pkg::dp_cmd_t   cmd,
	input  ipv6fp_pkg::in_item_t  item,
	output ipv6fp_pkg::dp_stat_t  stat,
	output ipv6fp_pkg::out_item_t result,
	output logic                 strobe
);
	import ipv6fp_pkg::*;

	logic [15:0] mtu_q;
	in_item_t    item_q;
	logic [15:0] maxsz_q;
	logic [15:0] rem_q;
	logic [15:0] pos_q;
	logic [13:0] off_q;
	logic        part_q;
	logic        pstart_q;
	logic [5:0]  cnt_q;
	out_item_t   result_q;
	logic        strobe_q;

	logic [16:0] total;
	logic        fits;
	logic        frag_bad;
	logic [15:0] mtu_less;
	logic [15:0] maxsz_d;
	logic        more_pkt;
	logic        more_after;
	logic        over;
	logic [15:0] this_sz;
	logic        body_nz;
	logic        to_body;
	logic        emit;
	out_item_t   res_d;

	always_comb begin
		total    = IPV6_HDR_LEN
			+ (item_q.has_fragment_header ? FRAG_HDR_LEN : 17'd0)
			+ 17'(item_q.head_size) + 17'(item_q.body_size);
		fits     = total <= {1'b0, mtu_q};
		body_nz  = item_q.body_size != 16'd0;
		frag_bad = (item_q.head_size[2:0] != 3'd0) || (mtu_q < MIN_FRAG_MTU)
			|| ((item_q.head_size == 8'd0) && !body_nz);
		mtu_less = mtu_q - FRAG_OVERHEAD;
		maxsz_d  = {mtu_less[15:3], 3'b000};
		more_pkt = item_q.has_fragment_header & item_q.in_mf_flag;
		more_after = part_q ? more_pkt : (body_nz | more_pkt);
		over     = rem_q > maxsz_q;
		this_sz  = over ? maxsz_q : rem_q;
		to_body  = !over && !part_q && body_nz;

		res_d     = '0;
		emit      = 1'b0;
		stat.done = 1'b0;

		if (cmd.eval) begin
			if (fits) begin
				emit                 = 1'b1;
				stat.done            = 1'b1;
				res_d.result_kind    = KIND_WHOLE;
				res_d.frag_offset    = item_q.has_fragment_header ?
					item_q.in_frag_offset : 13'd0;
				res_d.frag_size      = 16'(17'(item_q.head_size) + 17'(item_q.body_size));
				res_d.mf_flag        = more_pkt;
				res_d.last           = 1'b1;
			end else if (item_q.no_frag) begin
				emit              = 1'b1;
				stat.done         = 1'b1;
				res_d.result_kind = KIND_REPORT;
				res_d.report_mtu  = mtu_q - REPORT_DELTA;
				res_d.last        = 1'b1;
			end else if (frag_bad) begin
				emit              = 1'b1;
				stat.done         = 1'b1;
				res_d.result_kind = KIND_DROPPED;
				res_d.last        = 1'b1;
			end
		end else if (cmd.cut) begin
			emit = 1'b1;
			if ((pstart_q && more_after && (rem_q[2:0] != 3'd0))
				|| off_q[13] || (cnt_q == LAST_FRAG_IDX)) begin
				stat.done         = 1'b1;
				res_d.result_kind = KIND_DROPPED;
				res_d.last        = 1'b1;
			end else begin
				stat.done              = !over && !to_body;
				res_d.result_kind      = KIND_FRAG;
				res_d.frag_offset      = off_q[12:0];
				res_d.part_select      = part_q;
				res_d.part_byte_offset = pos_q;
				res_d.frag_size        = this_sz;
				res_d.mf_flag          = over | more_after;
				res_d.new_frag_header  = !item_q.has_fragment_header;
				res_d.last             = !over && !to_body;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mtu_q    <= MTU_RESET;
			strobe_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mtu_q <= cfg_wdata;
			end
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (emit) begin
			result_q <= res_d;
		end
		if (cmd.eval) begin
			maxsz_q  <= maxsz_d;
			off_q    <= item_q.has_fragment_header ? {1'b0, item_q.in_frag_offset} : 14'd0;
			cnt_q    <= 6'd0;
			pstart_q <= 1'b1;
			pos_q    <= 16'd0;
			if (item_q.head_size != 8'd0) begin
				part_q <= 1'b0;
				rem_q  <= 16'(item_q.head_size);
			end else begin
				part_q <= 1'b1;
				rem_q  <= item_q.body_size;
			end
		end else if (cmd.cut) begin
			cnt_q <= cnt_q + 6'd1;
			off_q <= off_q + 14'(this_sz[15:3]);
			if (to_body) begin
				part_q   <= 1'b1;
				rem_q    <= item_q.body_size;
				pos_q    <= 16'd0;
				pstart_q <= 1'b1;
			end else begin
				rem_q    <= rem_q - this_sz;
				pos_q    <= pos_q + this_sz;
				pstart_q <= 1'b0;
			end
		end
	end

	assign result = result_q;
	assign strobe = strobe_q;

endmodule
`default_nettype wire

// ===== rtl/ipv6_fragment_planner_top.sv =====
// IPv6 fragment planner.
// Input: an item is taken at a clock edge with start high and busy low.
// Each item yields one or more result beats on result, each marked by strobe
// for exactly one cycle; the receiver always takes them (no backpressure).
// The final beat of an item has result.last set.
// Config: cfg_we writes cfg_wdata to the outbound MTU register (reset 1500);
// write only while busy is low and no result is pending.
// Timing: acceptance is followed by an evaluation state, then by the cut
// sequencer. A whole packet, report or drop is settled in the evaluation
// state, after which busy falls; a fragmented packet holds busy through the
// evaluation state and the cut state, which gives each result in turn.
// Each strobe is registered from the state that made its result; results
// follow on consecutive cycles. A new item may be started on the cycle the
// last result is shown. The cutting loop issues one fragment per cycle.
// Reset: arst_n low clears the controller to idle, drops strobe and restores
// the MTU register to 1500.
`default_nettype none
module ipv6_fragment_planner_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  ipv6fp_pkg::in_item_t  item,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_wdata,
	output ipv6fp_pkg::out_item_t result,
	output logic                  strobe
);
	import ipv6fp_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ipv6fp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	ipv6fp_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.item      (item),
		.stat      (stat),
		.result    (result),
		.strobe    (strobe)
	);

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ipv6fp_pkg::*;

	localparam int unsigned MAX_FRAG_OFFSET = 8191;
	localparam int unsigned CYCLE_LIMIT     = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	in_item_t    item = '0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	out_item_t   result;
	logic        strobe;

	logic [15:0] link_mtu = MTU_RESET;
	out_item_t   planned_beats[$];
	int unsigned mismatch_count = 0;
	int unsigned packets_sent = 0;
	int unsigned beats_checked = 0;
	int unsigned mtu_settings = 0;
	int unsigned cycle_count = 0;

	ipv6_fragment_planner_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.result(result),
		.strobe(strobe)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
				planned_beats.size());
			$display("testbench failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h (beat %0d)", name, got, want,
				beats_checked));
	endtask

	// Expected beats for one packet at the current link MTU.
	function automatic void plan_fragments(input in_item_t pkt);
		out_item_t   beats[$];
		out_item_t   b;
		out_item_t   drop;
		int unsigned total, maxsz, offset, size, pos, chunk;
		logic        more_pkt, more_after, mf, nfh, ok;
		total = 32'(IPV6_HDR_LEN) + (pkt.has_fragment_header ? 32'(FRAG_HDR_LEN) : 0)
			+ 32'(pkt.head_size) + 32'(pkt.body_size);
		drop = '0;
		drop.result_kind = KIND_DROPPED;
		b = '0;
		if (total <= 32'(link_mtu)) begin
			b.result_kind = KIND_WHOLE;
			b.frag_offset = pkt.has_fragment_header ? pkt.in_frag_offset : '0;
			b.frag_size = 16'(32'(pkt.head_size) + 32'(pkt.body_size));
			b.mf_flag = pkt.has_fragment_header & pkt.in_mf_flag;
			beats.push_back(b);
		end else if (pkt.no_frag) begin
			b.result_kind = KIND_REPORT;
			b.report_mtu = link_mtu - REPORT_DELTA;
			beats.push_back(b);
		end else if (pkt.head_size[2:0] != 3'd0 || link_mtu < MIN_FRAG_MTU) begin
			beats.push_back(drop);
		end else begin
			maxsz = (32'(link_mtu) - 32'(FRAG_OVERHEAD)) & ~32'd7;
			offset = pkt.has_fragment_header ? 32'(pkt.in_frag_offset) : 0;
			more_pkt = pkt.has_fragment_header & pkt.in_mf_flag;
			nfh = ~pkt.has_fragment_header;
			ok = 1'b1;
			for (int part = 0; part < 2; part++) begin
				size = part ? 32'(pkt.body_size) : 32'(pkt.head_size);
				more_after = part ? more_pkt : (pkt.body_size != 0 || more_pkt);
				pos = 0;
				if (!ok || size == 0)
					continue;
				if (more_after && size % 8 != 0) begin
					beats.push_back(drop);
					ok = 1'b0;
					continue;
				end
				while (ok && size > 0) begin
					chunk = size < maxsz ? size : maxsz;
					mf = size > maxsz ? 1'b1 : more_after;
					if (offset > MAX_FRAG_OFFSET || beats.size() >= LAST_FRAG_IDX) begin
						beats.push_back(drop);
						ok = 1'b0;
					end else begin
						b = '0;
						b.result_kind = KIND_FRAG;
						b.frag_offset = 13'(offset);
						b.part_select = part[0];
						b.part_byte_offset = 16'(pos);
						b.frag_size = 16'(chunk);
						b.mf_flag = mf;
						b.new_frag_header = nfh;
						beats.push_back(b);
						pos += chunk;
						size -= chunk;
						offset += chunk / 8;
					end
				end
			end
			if (beats.size() == 0)
				beats.push_back(drop);
		end
		beats[beats.size() - 1].last = 1'b1;
		foreach (beats[i])
			planned_beats.push_back(beats[i]);
	endfunction

	always @(posedge clk) begin : check_beats
		out_item_t want;
		if (arst_n && strobe) begin
			if (planned_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected beat, kind %0d size %0d",
					result.result_kind, result.frag_size));
			end else begin
				want = planned_beats.pop_front();
				check_field("result_kind", 16'(result.result_kind), 16'(want.result_kind));
				check_field("frag_offset", 16'(result.frag_offset), 16'(want.frag_offset));
				check_field("part_select", 16'(result.part_select), 16'(want.part_select));
				check_field("part_byte_offset", result.part_byte_offset,
					want.part_byte_offset);
				check_field("frag_size", result.frag_size, want.frag_size);
				check_field("mf_flag", 16'(result.mf_flag),
					16'(want.mf_flag));
				check_field("new_frag_header", 16'(result.new_frag_header),
					16'(want.new_frag_header));
				check_field("report_mtu", result.report_mtu, want.report_mtu);
				check_field("last", 16'(result.last), 16'(want.last));
			end
			beats_checked++;
		end
	end

	// start stays high after acceptance so a following packet goes back to back
	task automatic offer_packet(input in_item_t pkt);
		item <= pkt;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		plan_fragments(pkt);
		packets_sent++;
	endtask

	task automatic hold_off(input int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_planned_empty();
		start <= 1'b0;
		while (planned_beats.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic program_mtu(input logic [15:0] value);
		wait_planned_empty();
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		link_mtu = value;
		mtu_settings++;
	endtask

	function automatic in_item_t make_pkt(input int unsigned head, input int unsigned body,
			input bit df, input bit hfh, input int unsigned off, input bit mf);
		in_item_t p;
		p.head_size = 8'(head);
		p.body_size = 16'(body);
		p.no_frag = df;
		p.has_fragment_header = hfh;
		p.in_frag_offset = 13'(off);
		p.in_mf_flag = mf;
		return p;
	endfunction

	function automatic in_item_t random_pkt();
		in_item_t p;
		p.head_size = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 248))
			: 8'($urandom_range(0, 31) * 8);
		case ($urandom_range(0, 3))
			0: p.body_size = 16'($urandom_range(0, 1400));
			1: p.body_size = 16'($urandom_range(1400, 9000));
			2: p.body_size = 16'($urandom);
			default: p.body_size = 16'($urandom_range(0, 255) * 8);
		endcase
		p.no_frag = ($urandom_range(0, 3) == 0);
		p.has_fragment_header = 1'($urandom_range(0, 1));
		p.in_frag_offset = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(8000, 8191))
			: 13'($urandom);
		p.in_mf_flag = 1'($urandom_range(0, 1));
		return p;
	endfunction

	task automatic test_whole_and_report();
		offer_packet(make_pkt(0, 0, 0, 0, 0, 0));
		offer_packet(make_pkt(248, 1212, 0, 0, 0, 0));
		offer_packet(make_pkt(248, 1204, 0, 1, 8191, 1));
		offer_packet(make_pkt(248, 1213, 1, 0, 0, 0));
		offer_packet(make_pkt(248, 65535, 1, 1, 8191, 1));
	endtask

	task automatic test_fragment_paths();
		program_mtu(16'd1280);
		offer_packet(make_pkt(248, 3000, 0, 0, 0, 0));
		offer_packet(make_pkt(16, 2000, 0, 1, 100, 1));
		offer_packet(make_pkt(7, 2000, 0, 0, 0, 0));
		offer_packet(make_pkt(16, 2001, 0, 1, 5, 1));
		offer_packet(make_pkt(0, 3001, 0, 1, 8190, 0));
	endtask

	task automatic test_mtu_extremes();
		program_mtu(16'd56);
		offer_packet(make_pkt(248, 20, 0, 0, 0, 0));
		offer_packet(make_pkt(0, 65535, 0, 0, 0, 0));
		offer_packet(make_pkt(24, 0, 0, 1, 10, 1));
		program_mtu(16'd55);
		offer_packet(make_pkt(0, 100, 0, 0, 0, 0));
		offer_packet(make_pkt(0, 100, 1, 0, 0, 0));
		program_mtu(16'd0);
		offer_packet(make_pkt(0, 0, 1, 0, 0, 0));
		offer_packet(make_pkt(0, 0, 0, 1, 0, 0));
		program_mtu(16'd65535);
		offer_packet(make_pkt(248, 65535, 0, 1, 8191, 0));
		offer_packet(make_pkt(248, 65535, 0, 0, 0, 0));
		offer_packet(make_pkt(0, 65487, 0, 0, 0, 0));
	endtask

	task automatic test_random_traffic();
		logic [15:0] phase_mtu[6];
		bit          pacing;
		phase_mtu[0] = 16'd1280;
		phase_mtu[1] = 16'd65535;
		phase_mtu[2] = 16'($urandom_range(1280, 65535));
		phase_mtu[3] = 16'($urandom_range(56, 1279));
		phase_mtu[4] = 16'($urandom_range(1280, 9000));
		phase_mtu[5] = MTU_RESET;
		for (int ph = 0; ph < 6; ph++) begin
			program_mtu(phase_mtu[ph]);
			pacing = 1'b1;
			for (int n = 0; n < 50; n++) begin
				if (n % 10 == 0)
					pacing = ($urandom_range(0, 2) != 0);
				if (ph == 2 && n == 25)
					wait_planned_empty();
				if (ph < 5 && pacing && $urandom_range(0, 2) == 0)
					hold_off($urandom_range(1, 15));
				offer_packet(random_pkt());
			end
		end
	endtask

	initial begin
		int unsigned guard;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_whole_and_report();
		test_fragment_paths();
		test_mtu_extremes();
		test_random_traffic();
		start <= 1'b0;
		guard = 0;
		while (planned_beats.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (planned_beats.size() != 0)
			report_mismatch($sformatf("%0d expected beats never arrived",
				planned_beats.size()));
		$display("%0d packets over %0d MTU settings, %0d result beats checked",
			packets_sent, mtu_settings, beats_checked);
		$display("whole, report, fragment and drop paths; %0d mismatches",
			mismatch_count);
		if (mismatch_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
`default_nettype wire
